// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define VPU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpu: implication failed");

// Next-cycle implication, off during reset.
`define VPU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpu: next-cycle implication failed");

// Holds in the cycle after a reset cycle.
`define VPU_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("vpu: post-reset check failed");

`endif

// ===== rtl/vpu_pkg.sv =====
package vpu_pkg;

  localparam int POS_W   = 22;
  localparam int DT_W    = 32;
  localparam int CELL_W  = 5;
  localparam int RAD_W   = 21;
  localparam int GRAV_W  = 22;
  localparam int EXT_W   = 21;
  localparam int CIS_W   = 24;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 2;
  localparam int ROOT_W  = 22;
  localparam int SQ_W    = 44;
  localparam int PROD_W  = 43;
  localparam int GP_W    = 54;
  localparam int G_W     = 23;
  localparam int V_W     = 25;
  localparam int ADJ_W   = 24;
  localparam int CP_W    = 47;
  localparam int IDXC_W  = 15;

  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 152;

  localparam int CELLS_PER_AXIS_DEF = 32;

  localparam logic [RAD_W-1:0]  BOUND_RADIUS_RST = 21'd448921;
  localparam logic [GRAV_W-1:0] GRAVITY_RST      = 22'd655360;
  localparam logic [EXT_W-1:0]  GRID_HALF_RST    = 21'd557056;
  localparam logic [CIS_W-1:0]  CELL_INV_RST     = 24'd123362;

  typedef enum logic [IDX_W-1:0] {
    REG_BOUND_RADIUS = 2'd0,
    REG_GRAVITY      = 2'd1,
    REG_GRID_HALF    = 2'd2,
    REG_CELL_INV     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0]  p;
    logic [2:0][POS_W-1:0]  o;
    logic                   clamp;
    logic [G_W-1:0]         g;
    logic [2:0][PROD_W-1:0] prod;
  } vpu_item_t;

endpackage

// ===== rtl/vpu_isqrt.sv =====
module vpu_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vpu_pkg::SQ_W-1:0]    radicand,
  output logic [vpu_pkg::ROOT_W-1:0]  root
);
  import vpu_pkg::*;

  logic [SQ_W-1:0] rem_q  [ROOT_W];
  logic [SQ_W-1:0] res_q  [ROOT_W];
  logic [SQ_W-1:0] rem_prev [ROOT_W];
  logic [SQ_W-1:0] res_prev [ROOT_W];
  logic [SQ_W-1:0] rem_next [ROOT_W];
  logic [SQ_W-1:0] res_next [ROOT_W];

  always_comb begin
    rem_prev[0] = radicand;
    res_prev[0] = '0;
    for (int k = 1; k < ROOT_W; k++) begin
      rem_prev[k] = rem_q[k-1];
      res_prev[k] = res_q[k-1];
    end
  end

  // one result bit per stage
  always_comb begin
    logic [SQ_W-1:0] bit_v;
    logic [SQ_W-1:0] trial;
    bit_v = '0;
    trial = '0;
    for (int k = 0; k < ROOT_W; k++) begin
      bit_v = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
      trial = res_prev[k] + bit_v;
      if (rem_prev[k] >= trial) begin
        rem_next[k] = rem_prev[k] - trial;
        res_next[k] = (res_prev[k] >> 1) + bit_v;
      end else begin
        rem_next[k] = rem_prev[k];
        res_next[k] = res_prev[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q <= rem_next;
      res_q <= res_next;
    end
  end

  assign root = res_q[ROOT_W-1][ROOT_W-1:0];

endmodule

// ===== rtl/vpu_div.sv =====
module vpu_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic [2:0][vpu_pkg::PROD_W-1:0]    dividend,
  input  logic [vpu_pkg::ROOT_W-1:0]         divisor,
  output logic [2:0][vpu_pkg::ROOT_W-1:0]    quotient
);
  import vpu_pkg::*;

  logic [SQ_W-1:0]   rem_q  [ROOT_W][3];
  logic [ROOT_W-1:0] quo_q  [ROOT_W][3];
  logic [ROOT_W-1:0] dvs_q  [ROOT_W];
  logic [SQ_W-1:0]   rem_prev [ROOT_W][3];
  logic [ROOT_W-1:0] quo_prev [ROOT_W][3];
  logic [ROOT_W-1:0] dvs_prev [ROOT_W];
  logic [SQ_W-1:0]   rem_next [ROOT_W][3];
  logic [ROOT_W-1:0] quo_next [ROOT_W][3];

  always_comb begin
    dvs_prev[0] = divisor;
    for (int i = 0; i < 3; i++) begin
      rem_prev[0][i] = SQ_W'(dividend[i]);
      quo_prev[0][i] = '0;
    end
    for (int k = 1; k < ROOT_W; k++) begin
      dvs_prev[k] = dvs_q[k-1];
      for (int i = 0; i < 3; i++) begin
        rem_prev[k][i] = rem_q[k-1][i];
        quo_prev[k][i] = quo_q[k-1][i];
      end
    end
  end

  // restoring divide, one quotient bit per stage, msb first
  always_comb begin
    logic [SQ_W-1:0] trial;
    trial = '0;
    for (int k = 0; k < ROOT_W; k++) begin
      trial = SQ_W'(dvs_prev[k]) << (ROOT_W - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (rem_prev[k][i] >= trial) begin
          rem_next[k][i] = rem_prev[k][i] - trial;
          quo_next[k][i] = quo_prev[k][i] | (ROOT_W'(1) << (ROOT_W - 1 - k));
        end else begin
          rem_next[k][i] = rem_prev[k][i];
          quo_next[k][i] = quo_prev[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
      dvs_q <= dvs_prev;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) quotient[i] = quo_q[ROOT_W-1][i];
  end

endmodule

// ===== rtl/verlet_particle_update_unit.sv =====
// Verlet particle update, one particle per item.
// Path: input register, products, bound test, square root, divider, integration, cell product, output register.
// Throughput: one item per cycle; the 22-stage square root and the 22-stage
// divider are fully pipelined and the whole pipe advances unless the output stalls.
// Reset (synchronous, rst high): pipeline emptied, config registers take reset values.
module verlet_particle_update_unit #(
  parameter int CELLS_PER_AXIS = vpu_pkg::CELLS_PER_AXIS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pos_x, pos_y, pos_z, old_x, old_y, old_z, dt_squared
  input  logic [vpu_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // next_x, next_y, next_z, keep_x, keep_y, keep_z, cell_x, cell_y, cell_z
  output logic [vpu_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic [vpu_pkg::IDX_W-1:0]          cfg_index,
  input  logic [vpu_pkg::CFG_W-1:0]          cfg_data
);
  import vpu_pkg::*;
  `include "assert_macros.svh"

  localparam logic [IDXC_W-1:0] CELL_LAST = IDXC_W'(CELLS_PER_AXIS - 1);
  localparam logic signed [V_W-1:0] V_MAX = 25'sd2097151;
  localparam logic signed [V_W-1:0] V_MIN = -25'sd2097152;

  logic [RAD_W-1:0]  bound_radius;
  logic [GRAV_W-1:0] gravity;
  logic [EXT_W-1:0]  grid_half_extent;
  logic [CIS_W-1:0]  cell_inverse_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_radius      <= BOUND_RADIUS_RST;
      gravity           <= GRAVITY_RST;
      grid_half_extent  <= GRID_HALF_RST;
      cell_inverse_size <= CELL_INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOUND_RADIUS: bound_radius      <= cfg_data[RAD_W-1:0];
        REG_GRAVITY:      gravity           <= cfg_data[GRAV_W-1:0];
        REG_GRID_HALF:    grid_half_extent  <= cfg_data[EXT_W-1:0];
        REG_CELL_INV:     cell_inverse_size <= cfg_data[CIS_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // valid bits
  logic              v1, v2, v3, vi, vc;
  logic [ROOT_W-1:0] vs;
  logic [ROOT_W-1:0] vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      vs <= '0;   vd <= '0;
      vi <= 1'b0; vc <= 1'b0; m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      vs       <= {vs[ROOT_W-2:0], v3};
      vd       <= {vd[ROOT_W-2:0], vs[ROOT_W-1]};
      vi       <= vd[ROOT_W-1];
      vc       <= vi;
      m_tvalid <= vc;
    end
  end

  // stage 1: input register
  logic [2:0][POS_W-1:0] s1_p, s1_o;
  logic [DT_W-1:0]       s1_dt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_p[i] <= s_tdata[i*POS_W +: POS_W];
        s1_o[i] <= s_tdata[(3+i)*POS_W +: POS_W];
      end
      s1_dt <= s_tdata[6*POS_W +: DT_W];
    end
  end

  // stage 2: products
  logic [2:0][POS_W-1:0]  mag1;
  logic [2:0][POS_W-1:0]  s2_p, s2_o;
  logic [2:0][PROD_W-1:0] s2_sq, s2_prod;
  logic [SQ_W-1:0]        s2_r2;
  logic [GP_W-1:0]        s2_gp;

  always_comb begin
    for (int i = 0; i < 3; i++)
      mag1[i] = s1_p[i][POS_W-1] ? POS_W'(-s1_p[i]) : s1_p[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq[i]   <= PROD_W'(SQ_W'(mag1[i]) * SQ_W'(mag1[i]));
        s2_prod[i] <= PROD_W'(SQ_W'(mag1[i]) * SQ_W'(bound_radius));
      end
      s2_r2 <= SQ_W'(bound_radius) * SQ_W'(bound_radius);
      s2_gp <= GP_W'(gravity) * GP_W'(s1_dt);
      s2_p  <= s1_p;
      s2_o  <= s1_o;
    end
  end

  // stage 3: sum of squares, bound test, gravity rounding
  logic [SQ_W-1:0] s3_s;
  logic [SQ_W-1:0] sum2;
  vpu_item_t       s3_item;

  assign sum2 = SQ_W'(s2_sq[0]) + SQ_W'(s2_sq[1]) + SQ_W'(s2_sq[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_s          <= sum2;
      s3_item.p     <= s2_p;
      s3_item.o     <= s2_o;
      s3_item.clamp <= sum2 > s2_r2;
      s3_item.g     <= G_W'((s2_gp + GP_W'(64'h8000_0000)) >> 32);
      s3_item.prod  <= s2_prod;
    end
  end

  // square root, then divide; item data rides alongside
  logic [ROOT_W-1:0]           len;
  logic [2:0][ROOT_W-1:0]      quo;
  vpu_item_t                   d1 [ROOT_W];
  vpu_item_t                   d2 [ROOT_W];

  vpu_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s3_s),
    .root     (len)
  );

  vpu_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (d1[ROOT_W-1].prod),
    .divisor  (len),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= s3_item;
      d2[0] <= d1[ROOT_W-1];
      for (int k = 1; k < ROOT_W; k++) begin
        d1[k] <= d1[k-1];
        d2[k] <= d2[k-1];
      end
    end
  end

  // integration stage
  vpu_item_t                  it;
  logic signed [POS_W:0]      kq   [3];
  logic signed [V_W-1:0]      vsum [3];
  logic [2:0][POS_W-1:0]      keep_c, next_c;
  logic [2:0][POS_W-1:0]      si_keep, si_next;

  assign it = d2[ROOT_W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (it.clamp) begin
        kq[i] = it.p[i][POS_W-1] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      end else begin
        kq[i] = (POS_W+1)'($signed(it.p[i]));
      end
      keep_c[i] = kq[i][POS_W-1:0];
      vsum[i] = (V_W'($signed(keep_c[i])) <<< 1) - V_W'($signed(it.o[i]));
      if (i == 1) vsum[i] = vsum[i] - $signed(V_W'(it.g));
      if (vsum[i] > V_MAX)      next_c[i] = V_MAX[POS_W-1:0];
      else if (vsum[i] < V_MIN) next_c[i] = V_MIN[POS_W-1:0];
      else                      next_c[i] = vsum[i][POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      si_keep <= keep_c;
      si_next <= next_c;
    end
  end

  // cell product stage
  logic signed [ADJ_W-1:0] adj [3];
  logic [2:0]              sc_pos;
  logic [2:0][CP_W-1:0]    sc_prod;
  logic [2:0][POS_W-1:0]   sc_keep, sc_next;

  always_comb begin
    for (int i = 0; i < 3; i++)
      adj[i] = ADJ_W'($signed(si_next[i])) + $signed(ADJ_W'(grid_half_extent));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sc_pos[i]  <= adj[i] > 0;
        sc_prod[i] <= CP_W'(adj[i][ADJ_W-2:0]) * CP_W'(cell_inverse_size);
      end
      sc_keep <= si_keep;
      sc_next <= si_next;
    end
  end

  // output register
  logic [IDXC_W-1:0]      idx  [3];
  logic [2:0][CELL_W-1:0] cell_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      idx[i] = sc_prod[i][32 +: IDXC_W];
      if (!sc_pos[i])            cell_c[i] = '0;
      else if (idx[i] > CELL_LAST) cell_c[i] = CELL_LAST[CELL_W-1:0];
      else                       cell_c[i] = idx[i][CELL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_tdata[i*POS_W +: POS_W]                <= sc_next[i];
        m_tdata[(3+i)*POS_W +: POS_W]            <= sc_keep[i];
        m_tdata[6*POS_W + i*CELL_W +: CELL_W]    <= cell_c[i];
      end
      m_tdata[OUT_TDATA_W-1:6*POS_W+3*CELL_W] <= '0;
    end
  end

  `VPU_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
  `VPU_ASSERT_NXT(a_accept_enters_pipe, s_tvalid && s_tready, v1)
  `VPU_ASSERT_NXT(a_stall_freezes_tail, m_tvalid && !m_tready && vc, vc)
  `VPU_ASSERT_RST(a_reset_empties, !m_tvalid && !v1 && vs == '0)

endmodule

// ===== dv/verlet_particle_update_unit_tb.sv =====
`timescale 1ns / 1ps

module verlet_particle_update_unit_tb;
  import vpu_pkg::*;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // pos_x, pos_y, pos_z, old_x, old_y, old_z, dt_squared
  logic [IN_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  // next_x, next_y, next_z, keep_x, keep_y, keep_z, cell_x, cell_y, cell_z
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  localparam logic signed [63:0] PMAX = 64'sd2097151;
  localparam logic signed [63:0] PMIN = -64'sd2097152;

  // last field in the lowest bits
  typedef struct packed {
    logic [CELL_W-1:0] cz, cy, cx;
    logic [POS_W-1:0] kz, ky, kx, nz, ny, nx;
  } particle_out_t;

  logic [63:0] radius_q, grav_q, half_q, cinv_q;
  particle_out_t update_q[$];
  int errors;
  int send_idle, recv_idle;

  verlet_particle_update_unit DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] root_of(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [CELL_W-1:0] cell_index(logic signed [63:0] p);
    logic signed [63:0] adj;
    logic [63:0] idx;
    adj = p + $signed(half_q);
    if (adj <= 0) return '0;
    idx = (64'(adj) * cinv_q) >> 32;
    if (idx > 31) idx = 31;
    return idx[CELL_W-1:0];
  endfunction

  function automatic particle_out_t particle_update(logic [IN_TDATA_W-1:0] d);
    logic signed [63:0] p[3], o[3], k[3], n[3], v;
    logic [63:0] s, len, g, mag;
    particle_out_t r;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(d[i*POS_W +: POS_W]);
      o[i] = $signed(d[(3+i)*POS_W +: POS_W]);
      s += 64'(p[i] * p[i]);
    end
    if (s > radius_q * radius_q) begin
      len = root_of(s);
      for (int i = 0; i < 3; i++) begin
        mag = p[i] < 0 ? 64'(-p[i]) : 64'(p[i]);
        mag = (mag * radius_q) / len;
        k[i] = p[i] < 0 ? -$signed(mag) : $signed(mag);
      end
    end else begin
      for (int i = 0; i < 3; i++) k[i] = p[i];
    end
    g = (grav_q * 64'(d[6*POS_W +: DT_W]) + (64'd1 << 31)) >> 32;
    for (int i = 0; i < 3; i++) begin
      v = 2 * k[i] - o[i];
      if (i == 1) v -= $signed(g);
      n[i] = v > PMAX ? PMAX : (v < PMIN ? PMIN : v);
    end
    r.nx = n[0][POS_W-1:0]; r.ny = n[1][POS_W-1:0]; r.nz = n[2][POS_W-1:0];
    r.kx = k[0][POS_W-1:0]; r.ky = k[1][POS_W-1:0]; r.kz = k[2][POS_W-1:0];
    r.cx = cell_index(n[0]); r.cy = cell_index(n[1]); r.cz = cell_index(n[2]);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_BOUND_RADIUS: radius_q = val[RAD_W-1:0];
      REG_GRAVITY:      grav_q = val[GRAV_W-1:0];
      REG_GRID_HALF:    half_q = val[EXT_W-1:0];
      default:          cinv_q = val[CIS_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic send_particle(logic [IN_TDATA_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= d;
    update_q = {update_q, particle_update(d)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (update_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_in(logic [POS_W-1:0] px, py, pz, ox, oy, oz,
                                                   logic [DT_W-1:0] dt);
    return {dt, oz, oy, ox, pz, py, px};
  endfunction

  function automatic logic [POS_W-1:0] rnd_pos(int inner);
    int m;
    m = $urandom_range(9);
    if (m == 0) return 22'h1FFFFF;
    if (m == 1) return 22'h200000;
    if (inner != 0 && m < 7) return POS_W'($signed(22'($urandom_range(2000000))) - 1000000);
    return POS_W'($urandom);
  endfunction

  task automatic test_directed;
    logic [POS_W-1:0] mx, mn;
    mx = 22'h1FFFFF; mn = 22'h200000;
    send_particle(pack_in(0, 0, 0, 0, 0, 0, 0));
    send_particle(pack_in(mx, mx, mx, mn, mn, mn, 32'hFFFFFFFF));
    send_particle(pack_in(mn, mn, mn, mx, mx, mx, 32'hFFFFFFFF));
    send_particle(pack_in(mx, 0, 0, 0, 0, 0, 0));
    send_particle(pack_in(0, mn, 0, 0, 0, 0, 32'h80000000));
    send_particle(pack_in(22'd65536, 22'd65536, 0, 22'd60000, 22'd65000, 0, 32'd1000));
    send_particle(pack_in(22'd448921, 0, 0, 22'd448921, 0, 0, 0));
    send_particle(pack_in(22'd448922, 0, 0, 0, 0, 0, 0));
    send_particle(pack_in(22'h3C0000, 22'h3C0000, 22'h3C0000, 0, 0, 0, 32'h01000000));
    drain();
    write_reg(REG_BOUND_RADIUS, 0);
    write_reg(REG_GRAVITY, 24'h3FFFFF);
    send_particle(pack_in(1, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
    send_particle(pack_in(mx, mn, 22'h3FFFFF, 1, 2, 3, 32'hFFFFFFFF));
    send_particle(pack_in(0, 0, 0, mn, mx, mn, 32'hFFFFFFFF));
    drain();
    write_reg(REG_BOUND_RADIUS, 24'h1FFFFF);
    write_reg(REG_GRID_HALF, 24'h1FFFFF);
    write_reg(REG_CELL_INV, 24'hFFFFFF);
    write_reg(REG_GRAVITY, 0);
    send_particle(pack_in(mx, mx, mx, mn, mn, mn, 32'hFFFFFFFF));
    send_particle(pack_in(mn, mn, mn, mx, mx, mx, 0));
    send_particle(pack_in(22'd1000, 22'h3FF000, 22'd5, 22'd7, 22'd9, 22'd11, 32'h1234));
    drain();
    write_reg(REG_GRID_HALF, 0);
    write_reg(REG_CELL_INV, 0);
    send_particle(pack_in(22'd1000, 22'd2000, 22'h3FF000, 0, 0, 0, 32'h5555));
    send_particle(pack_in(mn, mx, 0, 0, 0, 0, 32'hAAAAAAAA));
    drain();
  endtask

  task automatic test_random(int count);
    logic [DT_W-1:0] dt;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        drain();
        write_reg(REG_BOUND_RADIUS, $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(600000)));
        write_reg(REG_GRAVITY, 24'($urandom));
        write_reg(REG_GRID_HALF, $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(700000)));
        write_reg(REG_CELL_INV, $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(200000)));
      end
      dt = $urandom_range(3) == 0 ? $urandom : $urandom_range(50000000);
      send_particle(pack_in(rnd_pos(1), rnd_pos(1), rnd_pos(1),
                            rnd_pos(1), rnd_pos(1), rnd_pos(1), dt));
    end
    drain();
  endtask

  always @(posedge clk) begin
    particle_out_t got, want;
    if (!rst) m_tready <= ($urandom_range(99) >= recv_idle);
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(particle_out_t)-1:0];
      if (update_q.size() == 0) begin
        report_mismatch("unexpected item", 64'(m_tdata), 0);
      end else begin
        want = update_q.pop_front();
        if (got.nx != want.nx) report_mismatch("next_x", got.nx, want.nx);
        if (got.ny != want.ny) report_mismatch("next_y", got.ny, want.ny);
        if (got.nz != want.nz) report_mismatch("next_z", got.nz, want.nz);
        if (got.kx != want.kx) report_mismatch("keep_x", got.kx, want.kx);
        if (got.ky != want.ky) report_mismatch("keep_y", got.ky, want.ky);
        if (got.kz != want.kz) report_mismatch("keep_z", got.kz, want.kz);
        if (got.cx != want.cx) report_mismatch("cell_x", got.cx, want.cx);
        if (got.cy != want.cy) report_mismatch("cell_y", got.cy, want.cy);
        if (got.cz != want.cz) report_mismatch("cell_z", got.cz, want.cz);
      end
    end
  end

  initial begin
    #20ms;
    $display("verlet_particle_update_unit_tb: done, errors");
    $finish;
  end

  initial begin
    errors = 0;
    rst = 1; s_tvalid = 0; s_tdata = '0; m_tready = 0;
    cfg_we = 0; cfg_index = REG_BOUND_RADIUS; cfg_data = '0;
    radius_q = BOUND_RADIUS_RST; grav_q = GRAVITY_RST;
    half_q = GRID_HALF_RST; cinv_q = CELL_INV_RST;
    send_idle = 32; recv_idle = 78;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(450);
    send_idle = 78; recv_idle = 32;
    test_random(450);
    send_idle = 0; recv_idle = 0;
    test_random(450);
    if (errors == 0 && update_q.size() == 0) begin
      $display("verlet_particle_update_unit_tb: done, clean");
    end else begin
      $display("verlet_particle_update_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
